@@ src/trilateration_three_anchors_top_defines.svh @@
// Assertion macros for the three-anchor trilateration block.
// Used by the port checker; depends on nothing else.
`ifndef TRILATERATION_THREE_ANCHORS_TOP_DEFINES_SVH
`define TRILATERATION_THREE_ANCHORS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRI3A_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tri3a port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRI3A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tri3a port check failed");

`endif

@@ src/tri3a_pkg.sv @@
`timescale 1ns / 1ps
// Package for the three-anchor trilateration block: widths, status codes and beat types.
// Used by the divider, the top level and the port checker; depends on nothing.
package tri3a_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;

    localparam int DIFF_W = COORD_WIDTH + 1;          // coordinate difference
    localparam int SQ_W   = 2 * COORD_WIDTH;          // square of a coordinate
    localparam int LIN_W  = 2 * COORD_WIDTH + 2;      // right-hand side of a line
    localparam int LO_W   = DIFF_W;                   // low slice of a line term
    localparam int HI_W   = LIN_W - LO_W;             // high slice of a line term
    localparam int PROD_W = LIN_W + DIFF_W + 1;       // numerator of the crossing
    localparam int DEN_W  = 2 * DIFF_W + 2;           // denominator of the crossing
    localparam int D2_W   = DEN_W + 1;
    localparam int REM_W  = D2_W + COORD_WIDTH;
    localparam int DIV_LAT = COORD_WIDTH + 2;

    // 0.01 m rounded to the nearest LSB, capped to the register width.
    localparam int TOL_RAW = ((1 << FRAC_BITS) + 50) / 100;
    localparam logic [7:0] TOL_RESET = (TOL_RAW > 255) ? 8'd255 : 8'(TOL_RAW);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOPAIR   = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] anchor1_x;
        logic signed [COORD_WIDTH-1:0] anchor1_y;
        logic        [COORD_WIDTH-2:0] anchor1_range;
        logic signed [COORD_WIDTH-1:0] anchor2_x;
        logic signed [COORD_WIDTH-1:0] anchor2_y;
        logic        [COORD_WIDTH-2:0] anchor2_range;
        logic signed [COORD_WIDTH-1:0] anchor3_x;
        logic signed [COORD_WIDTH-1:0] anchor3_y;
        logic        [COORD_WIDTH-2:0] anchor3_range;
    } in_t;

    typedef struct packed {
        logic        [1:0]             status;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
    } out_t;

endpackage

@@ src/tri3a_div.sv @@
`timescale 1ns / 1ps
// Pipelined rounding divider: one quotient bit per stage, saturated signed result.
// Depends on tri3a_pkg.
module tri3a_div (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic [tri3a_pkg::PROD_W-1:0]              num_abs,
    input  logic [tri3a_pkg::DEN_W-1:0]               den_abs,
    input  logic                                      neg,
    output logic signed [tri3a_pkg::COORD_WIDTH-1:0]  quo
);
    import tri3a_pkg::*;

    localparam int QW = COORD_WIDTH;

    logic [REM_W-1:0] rem_reg [0:QW];
    logic [D2_W-1:0]  d2_reg  [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];
    logic             neg_reg [0:QW];
    logic             ovf_reg [0:QW];
    logic signed [QW-1:0] quo_reg;

    logic [QW-1:0] limit;
    logic [QW-1:0] q_sat;

    // Rounding to nearest is folded in as floor((2|n| + |d|) / (2|d|)).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= (REM_W'(num_abs) << 1) + REM_W'(den_abs);
            d2_reg[0]  <= D2_W'(den_abs) << 1;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= 1'b0;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int BIT = QW - 1 - j;
        logic [REM_W-1:0] shifted;
        logic             fits;
        logic             ovf_next;

        always_comb
        begin
            shifted = REM_W'(d2_reg[j]) << BIT;
            fits    = rem_reg[j] >= shifted;
            if (j == 0)
                ovf_next = rem_reg[j] >= (REM_W'(d2_reg[j]) << QW);
            else
                ovf_next = ovf_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= fits ? rem_reg[j] - shifted : rem_reg[j];
                q_reg[j+1]   <= fits ? (q_reg[j] | (QW'(1) << BIT)) : q_reg[j];
                d2_reg[j+1]  <= d2_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_next;
            end
        end
    end

    always_comb
    begin
        limit = neg_reg[QW] ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - QW'(1));
        q_sat = (ovf_reg[QW] || (q_reg[QW] > limit)) ? limit : q_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= neg_reg[QW] ? $signed(-q_sat) : $signed(q_sat);
    end

    assign quo = quo_reg;

endmodule

@@ src/trilateration_three_anchors_top.sv @@
`timescale 1ns / 1ps
// Three-anchor trilateration: solves the crossing of two range-circle lines per beat.
// Depends on tri3a_pkg and tri3a_div.
//
// One anchor set is taken per clock cycle while in_ready is high; its result passes
// through six arithmetic stages (squares, line terms, pair choice, split products,
// sums, magnitudes), then two 26-stage dividers working side by side, one quotient
// bit per stage, then the output register. The dividers are the deepest part. A
// result waiting at the output is backed by a one-entry skid register, so input is
// only refused while both hold a result.
module trilateration_three_anchors_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tri3a_pkg::in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output tri3a_pkg::out_t out_data,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata
);
    import tri3a_pkg::*;

    logic       adv;
    logic [7:0] tol_reg;
    logic [6:1] v_reg;
    logic       v_dly_reg [DIV_LAT];
    logic [1:0] st_dly_reg [DIV_LAT];

    // Stage 1
    logic        [SQ_W-1:0]   sqx_reg [3];
    logic        [SQ_W-1:0]   sqy_reg [3];
    logic        [SQ_W-1:0]   sqr_reg [3];
    logic signed [DIFF_W-1:0] dx1_reg [3];
    logic signed [DIFF_W-1:0] dy1_reg [3];
    logic signed [SQ_W-1:0]   sqx_next [3];
    logic signed [SQ_W-1:0]   sqy_next [3];
    logic        [SQ_W-1:0]   sqr_next [3];
    // Stage 2
    logic signed [LIN_W-1:0]  n2_reg  [3];
    logic signed [DIFF_W-1:0] dx2_reg [3];
    logic signed [DIFF_W-1:0] dy2_reg [3];
    logic        [2:0]        dist_reg;
    logic        [2:0]        dist_next;
    logic signed [LIN_W-1:0]  n2_next [3];
    // Stage 3
    logic signed [DIFF_W-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [LIN_W-1:0]  l1_reg, l2_reg;
    logic                     nopair3_reg;
    // Stage 4
    logic signed [2*DIFF_W-1:0]      dp_reg [2];
    logic signed [HI_W+DIFF_W-1:0]   pph_reg [4];
    logic signed [LO_W+DIFF_W:0]     ppl_reg [4];
    logic                            nopair4_reg;
    logic signed [LIN_W-1:0]         pn [4];
    logic signed [DIFF_W-1:0]        pm [4];
    // Stage 5
    logic signed [PROD_W-1:0] nx_reg, ny_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic                     nopair5_reg;
    logic signed [PROD_W-1:0] full [4];
    // Stage 6
    logic [PROD_W-1:0] nxa_reg, nya_reg;
    logic [DEN_W-1:0]  dena_reg;
    logic              negx_reg, negy_reg;
    logic [1:0]        st6_reg;

    logic signed [COORD_WIDTH-1:0] quo_x, quo_y;

    out_t res;
    out_t out_reg, skid_reg;
    logic out_v_reg, skid_v_reg;
    logic inc;
    logic out_free;

    assign adv      = ~skid_v_reg;
    assign in_ready = adv;

    // Control: tolerance register and beat valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            v_reg   <= '0;
            for (int k = 0; k < DIV_LAT; k++)
                v_dly_reg[k] <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (adv)
            begin
                v_reg <= {v_reg[5:1], in_valid};
                v_dly_reg[0] <= v_reg[6];
                for (int k = 1; k < DIV_LAT; k++)
                    v_dly_reg[k] <= v_dly_reg[k-1];
            end
        end
    end

    // Stage 1: squares and coordinate differences (pairs 1-2, 1-3, 2-3).
    always_comb
    begin
        sqx_next[0] = in_data.anchor1_x * in_data.anchor1_x;
        sqx_next[1] = in_data.anchor2_x * in_data.anchor2_x;
        sqx_next[2] = in_data.anchor3_x * in_data.anchor3_x;
        sqy_next[0] = in_data.anchor1_y * in_data.anchor1_y;
        sqy_next[1] = in_data.anchor2_y * in_data.anchor2_y;
        sqy_next[2] = in_data.anchor3_y * in_data.anchor3_y;
        sqr_next[0] = SQ_W'(in_data.anchor1_range) * SQ_W'(in_data.anchor1_range);
        sqr_next[1] = SQ_W'(in_data.anchor2_range) * SQ_W'(in_data.anchor2_range);
        sqr_next[2] = SQ_W'(in_data.anchor3_range) * SQ_W'(in_data.anchor3_range);
    end

    // Stage 2: distinct-x flags and the right-hand side of each pair's line.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [DIFF_W-1:0] mag;
            mag = dx1_reg[k][DIFF_W-1] ? DIFF_W'(-dx1_reg[k]) : DIFF_W'(dx1_reg[k]);
            dist_next[k] = mag >= DIFF_W'(tol_reg);
        end
        n2_next[0] = $signed(LIN_W'(sqx_reg[0])) - $signed(LIN_W'(sqx_reg[1]))
                   + $signed(LIN_W'(sqy_reg[0])) - $signed(LIN_W'(sqy_reg[1]))
                   + $signed(LIN_W'(sqr_reg[1])) - $signed(LIN_W'(sqr_reg[0]));
        n2_next[1] = $signed(LIN_W'(sqx_reg[0])) - $signed(LIN_W'(sqx_reg[2]))
                   + $signed(LIN_W'(sqy_reg[0])) - $signed(LIN_W'(sqy_reg[2]))
                   + $signed(LIN_W'(sqr_reg[2])) - $signed(LIN_W'(sqr_reg[0]));
        n2_next[2] = $signed(LIN_W'(sqx_reg[1])) - $signed(LIN_W'(sqx_reg[2]))
                   + $signed(LIN_W'(sqy_reg[1])) - $signed(LIN_W'(sqy_reg[2]))
                   + $signed(LIN_W'(sqr_reg[2])) - $signed(LIN_W'(sqr_reg[1]));
    end

    // Stage 4 operands: the wide line terms are split into two narrower products; stage 5 rejoins them.
    always_comb
    begin
        pn[0] = l1_reg; pm[0] = b2_reg;
        pn[1] = l2_reg; pm[1] = b1_reg;
        pn[2] = l2_reg; pm[2] = a1_reg;
        pn[3] = l1_reg; pm[3] = a2_reg;
        for (int k = 0; k < 4; k++)
            full[k] = (PROD_W'(pph_reg[k]) <<< LO_W) + PROD_W'(ppl_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1
            for (int k = 0; k < 3; k++)
            begin
                sqx_reg[k] <= sqx_next[k];
                sqy_reg[k] <= sqy_next[k];
                sqr_reg[k] <= sqr_next[k];
            end
            dx1_reg[0] <= DIFF_W'(in_data.anchor1_x) - DIFF_W'(in_data.anchor2_x);
            dx1_reg[1] <= DIFF_W'(in_data.anchor1_x) - DIFF_W'(in_data.anchor3_x);
            dx1_reg[2] <= DIFF_W'(in_data.anchor2_x) - DIFF_W'(in_data.anchor3_x);
            dy1_reg[0] <= DIFF_W'(in_data.anchor1_y) - DIFF_W'(in_data.anchor2_y);
            dy1_reg[1] <= DIFF_W'(in_data.anchor1_y) - DIFF_W'(in_data.anchor3_y);
            dy1_reg[2] <= DIFF_W'(in_data.anchor2_y) - DIFF_W'(in_data.anchor3_y);

            // Stage 2
            for (int k = 0; k < 3; k++)
            begin
                n2_reg[k]  <= n2_next[k];
                dx2_reg[k] <= dx1_reg[k];
                dy2_reg[k] <= dy1_reg[k];
            end
            dist_reg <= dist_next;

            // Stage 3: first usable pair order wins.
            nopair3_reg <= 1'b0;
            if (dist_reg[0] && dist_reg[1])
            begin
                a1_reg <= dx2_reg[0]; b1_reg <= dy2_reg[0]; l1_reg <= n2_reg[0];
                a2_reg <= dx2_reg[1]; b2_reg <= dy2_reg[1]; l2_reg <= n2_reg[1];
            end
            else if (dist_reg[0] && dist_reg[2])
            begin
                a1_reg <= dx2_reg[0]; b1_reg <= dy2_reg[0]; l1_reg <= n2_reg[0];
                a2_reg <= dx2_reg[2]; b2_reg <= dy2_reg[2]; l2_reg <= n2_reg[2];
            end
            else
            begin
                a1_reg <= dx2_reg[2]; b1_reg <= dy2_reg[2]; l1_reg <= n2_reg[2];
                a2_reg <= dx2_reg[1]; b2_reg <= dy2_reg[1]; l2_reg <= n2_reg[1];
                nopair3_reg <= ~(dist_reg[2] && dist_reg[1]);
            end

            // Stage 4
            dp_reg[0] <= a1_reg * b2_reg;
            dp_reg[1] <= a2_reg * b1_reg;
            for (int k = 0; k < 4; k++)
            begin
                pph_reg[k] <= $signed(pn[k][LIN_W-1:LO_W]) * pm[k];
                ppl_reg[k] <= $signed({1'b0, pn[k][LO_W-1:0]}) * pm[k];
            end
            nopair4_reg <= nopair3_reg;

            // Stage 5
            nx_reg      <= full[0] - full[1];
            ny_reg      <= full[2] - full[3];
            den_reg     <= (DEN_W'(dp_reg[0]) - DEN_W'(dp_reg[1])) <<< 1;
            nopair5_reg <= nopair4_reg;

            // Stage 6: magnitudes and result signs for the dividers, and the status code.
            nxa_reg  <= nx_reg[PROD_W-1] ? PROD_W'(-nx_reg) : PROD_W'(nx_reg);
            nya_reg  <= ny_reg[PROD_W-1] ? PROD_W'(-ny_reg) : PROD_W'(ny_reg);
            dena_reg <= den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
            negx_reg <= nx_reg[PROD_W-1] ^ den_reg[DEN_W-1];
            negy_reg <= ny_reg[PROD_W-1] ^ den_reg[DEN_W-1];
            if (nopair5_reg)
                st6_reg <= ST_NOPAIR;
            else if (den_reg == '0)
                st6_reg <= ST_PARALLEL;
            else
                st6_reg <= ST_OK;

            st_dly_reg[0] <= st6_reg;
            for (int k = 1; k < DIV_LAT; k++)
                st_dly_reg[k] <= st_dly_reg[k-1];
        end
    end

    tri3a_div u_div_x (
        .clk     (clk),
        .en      (adv),
        .num_abs (nxa_reg),
        .den_abs (dena_reg),
        .neg     (negx_reg),
        .quo     (quo_x)
    );

    tri3a_div u_div_y (
        .clk     (clk),
        .en      (adv),
        .num_abs (nya_reg),
        .den_abs (dena_reg),
        .neg     (negy_reg),
        .quo     (quo_y)
    );

    always_comb
    begin
        res.status = st_dly_reg[DIV_LAT-1];
        res.pos_x  = (res.status == ST_OK) ? quo_x : '0;
        res.pos_y  = (res.status == ST_OK) ? quo_y : '0;
        inc        = v_dly_reg[DIV_LAT-1] & adv;
        out_free   = ~out_v_reg | out_ready;
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= inc;
        end
        else if (inc)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
                out_reg <= skid_reg;
            else if (inc)
                out_reg <= res;
        end
        else if (inc)
            skid_reg <= res;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

@@ src/tri3a_chk.sv @@
`timescale 1ns / 1ps
// Port checker for the trilateration block, bound to the top level.
// Depends on tri3a_pkg and the assertion macro header.
`include "trilateration_three_anchors_top_defines.svh"

module tri3a_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input tri3a_pkg::out_t out_data
);
    import tri3a_pkg::*;

    // A failed solve never reports a position.
    `TRI3A_ASSERT_NOW(a_zero_on_fail, clk, rst_n, out_valid && (out_data.status != ST_OK), (out_data.pos_x == '0) && (out_data.pos_y == '0))

    // Only the three defined status codes leave the block.
    `TRI3A_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, (out_data.status == ST_OK) || (out_data.status == ST_NOPAIR) || (out_data.status == ST_PARALLEL))

    // Input is refused only while a result is waiting at the output.
    `TRI3A_ASSERT_NOW(a_backpressure, clk, rst_n, !in_ready, out_valid)

    // A result not taken stays presented unchanged.
    `TRI3A_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind trilateration_three_anchors_top tri3a_chk u_tri3a_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the three-anchor trilateration block.
// Depends on tri3a_pkg and trilateration_three_anchors_top; predicts each fix exactly.
module testbench;
    import tri3a_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    logic [7:0] tolerance;
    out_t expected_fixes[$];
    int failures;
    int idle_cycles;
    bit quiet_sender;
    bit quiet_receiver;

    trilateration_three_anchors_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Rounds num/den to nearest, ties away from zero, then saturates.
    function automatic logic signed [CW-1:0] round_div(logic signed [127:0] num,
                                                        logic signed [127:0] den);
        logic neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = (2 * n + d) / (2 * d);
        if (neg)
        begin
            if (q > (128'd1 << (CW - 1)))
                q = 128'd1 << (CW - 1);
            return -q[CW-1:0];
        end
        if (q > (128'd1 << (CW - 1)) - 1)
            q = (128'd1 << (CW - 1)) - 1;
        return q[CW-1:0];
    endfunction

    function automatic bit x_distinct(logic signed [63:0] xa, logic signed [63:0] xb);
        logic signed [63:0] d;
        d = xa - xb;
        if (d < 0)
            d = -d;
        return d >= tolerance;
    endfunction

    function automatic out_t solve_fix(in_t a);
        logic signed [63:0] px[3];
        logic signed [63:0] py[3];
        logic signed [63:0] pr[3];
        int s1[2];
        int s2[2];
        logic signed [127:0] a1, b1, n1, a2, b2, n2, den, nx, ny;
        bit d12, d13, d23;
        out_t r;
        px[0] = 64'(a.anchor1_x); py[0] = 64'(a.anchor1_y); pr[0] = {41'd0, a.anchor1_range};
        px[1] = 64'(a.anchor2_x); py[1] = 64'(a.anchor2_y); pr[1] = {41'd0, a.anchor2_range};
        px[2] = 64'(a.anchor3_x); py[2] = 64'(a.anchor3_y); pr[2] = {41'd0, a.anchor3_range};
        d12 = x_distinct(px[0], px[1]);
        d13 = x_distinct(px[0], px[2]);
        d23 = x_distinct(px[1], px[2]);
        r = '0;
        r.status = ST_NOPAIR;
        if (d12 && d13)
        begin
            s1 = '{0, 1}; s2 = '{0, 2};
        end
        else if (d12 && d23)
        begin
            s1 = '{0, 1}; s2 = '{1, 2};
        end
        else if (d23 && d13)
        begin
            s1 = '{1, 2}; s2 = '{0, 2};
        end
        else
            return r;
        a1 = px[s1[0]] - px[s1[1]];
        b1 = py[s1[0]] - py[s1[1]];
        n1 = px[s1[0]] * px[s1[0]] - px[s1[1]] * px[s1[1]] + py[s1[0]] * py[s1[0]]
            - py[s1[1]] * py[s1[1]] + pr[s1[1]] * pr[s1[1]] - pr[s1[0]] * pr[s1[0]];
        a2 = px[s2[0]] - px[s2[1]];
        b2 = py[s2[0]] - py[s2[1]];
        n2 = px[s2[0]] * px[s2[0]] - px[s2[1]] * px[s2[1]] + py[s2[0]] * py[s2[0]]
            - py[s2[1]] * py[s2[1]] + pr[s2[1]] * pr[s2[1]] - pr[s2[0]] * pr[s2[0]];
        den = 2 * (a1 * b2 - a2 * b1);
        if (den == 0)
        begin
            r.status = ST_PARALLEL;
            return r;
        end
        nx = n1 * b2 - n2 * b1;
        ny = n2 * a1 - n1 * a2;
        r.status = ST_OK;
        r.pos_x = round_div(nx, den);
        r.pos_y = round_div(ny, den);
        return r;
    endfunction

    // Valid stays high after the beat is taken; the next call may lower it, the drain does.
    task automatic send_fix(in_t a);
        if (!quiet_sender)
            while ($urandom_range(99) < 10)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        in_data <= a;
        expected_fixes.push_back(solve_fix(a));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_then_idle();
        in_valid <= 1'b0;
        while (expected_fixes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_tolerance(logic [7:0] value);
        drain_then_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        tolerance = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return CW'($urandom);
            1: return {1'b0, {(CW - 1){1'b1}}};
            2: return {1'b1, {(CW - 1){1'b0}}};
            default: return CW'(int'($urandom_range(40000)) - 20000);
        endcase
    endfunction

    function automatic logic [CW-2:0] rand_range();
        if ($urandom_range(3) == 0)
            return (CW - 1)'($urandom);
        return (CW - 1)'($urandom_range(30000));
    endfunction

    // Anchors around a true point, so ranges are consistent and fixes land in range.
    function automatic in_t make_consistent(int spread);
        in_t a;
        int tx, ty;
        int ax[3], ay[3];
        tx = int'($urandom_range(2 * spread)) - spread;
        ty = int'($urandom_range(2 * spread)) - spread;
        for (int k = 0; k < 3; k++)
        begin
            ax[k] = int'($urandom_range(2 * spread)) - spread;
            ay[k] = int'($urandom_range(2 * spread)) - spread;
        end
        if ($urandom_range(7) == 0)
            ax[$urandom_range(2)] = ax[$urandom_range(2)] + int'($urandom_range(4));
        a.anchor1_x = CW'(ax[0]); a.anchor1_y = CW'(ay[0]);
        a.anchor2_x = CW'(ax[1]); a.anchor2_y = CW'(ay[1]);
        a.anchor3_x = CW'(ax[2]); a.anchor3_y = CW'(ay[2]);
        a.anchor1_range = (CW - 1)'($rtoi($sqrt(real'(tx - ax[0]) ** 2
                                               + real'(ty - ay[0]) ** 2)));
        a.anchor2_range = (CW - 1)'($rtoi($sqrt(real'(tx - ax[1]) ** 2
                                               + real'(ty - ay[1]) ** 2)));
        a.anchor3_range = (CW - 1)'($rtoi($sqrt(real'(tx - ax[2]) ** 2
                                               + real'(ty - ay[2]) ** 2)));
        return a;
    endfunction

    function automatic in_t make_noise();
        in_t a;
        a.anchor1_x = rand_coord(); a.anchor1_y = rand_coord(); a.anchor1_range = rand_range();
        a.anchor2_x = rand_coord(); a.anchor2_y = rand_coord(); a.anchor2_range = rand_range();
        a.anchor3_x = rand_coord(); a.anchor3_y = rand_coord(); a.anchor3_range = rand_range();
        return a;
    endfunction

    function automatic in_t anchors(int x1, int y1, int r1, int x2, int y2, int r2,
                                    int x3, int y3, int r3);
        in_t a;
        a.anchor1_x = CW'(x1); a.anchor1_y = CW'(y1); a.anchor1_range = (CW - 1)'(r1);
        a.anchor2_x = CW'(x2); a.anchor2_y = CW'(y2); a.anchor2_range = (CW - 1)'(r2);
        a.anchor3_x = CW'(x3); a.anchor3_y = CW'(y3); a.anchor3_range = (CW - 1)'(r3);
        return a;
    endfunction

    task automatic test_directed();
        int mx, mn, mr;
        mx = 8388607; mn = -8388608; mr = 8388607;
        // A clean fix at (1 m, 1 m) from anchors at the origin, (4,0) and (0,4).
        send_fix(anchors(0, 0, 362, 1024, 0, 810, 0, 1024, 810));
        // Close x on 1-3 picks the second pair order, on 2-3 the first, on 1-2 the third.
        send_fix(anchors(0, 0, 300, 1000, 0, 500, 1, 800, 700));
        send_fix(anchors(0, 0, 300, 1000, 0, 500, 1000, 800, 700));
        send_fix(anchors(0, 0, 300, 2, 100, 500, 900, 800, 700));
        // No usable pair: all x equal or within the tolerance.
        send_fix(anchors(5, 0, 10, 5, 100, 20, 7, 200, 30));
        // Collinear anchors give parallel lines.
        send_fix(anchors(0, 0, 10, 100, 100, 20, 300, 300, 30));
        // Extremes of every field, including saturation of both signs.
        send_fix(anchors(mx, mx, mr, mn, mn, 0, mx, mn, mr));
        send_fix(anchors(mn, mx, 0, mx, mn, mr, 0, 0, 0));
        send_fix(anchors(mn, 0, mr, mx, 0, 0, 0, 1, mr));
        send_fix(anchors(0, 0, 0, 3, 0, 0, 0, 3, mr));
        send_fix(anchors(-1, -1, 1, 1, 1, 1, 2, -2, 5));
        send_fix(anchors(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_fix(anchors(mx, 0, 0, mn, 0, 0, 0, mx, 0));
    endtask

    task automatic test_tolerance_settings();
        logic [7:0] settings[4];
        settings = '{8'd0, 8'd255, 8'd1, TOL_RESET};
        foreach (settings[i])
        begin
            set_tolerance(settings[i]);
            send_fix(anchors(0, 0, 300, 0, 100, 500, 900, 800, 700));
            send_fix(anchors(0, 0, 300, 200, 100, 500, 254, 800, 700));
            send_fix(anchors(0, 0, 300, 255, 100, 500, 600, 800, 700));
            for (int k = 0; k < 30; k++)
                send_fix(make_consistent(2000));
        end
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
        begin
            quiet_sender = (k >= count / 2) && (k < count / 2 + 200);
            quiet_receiver = quiet_sender;
            if ($urandom_range(9) < 7)
                send_fix(make_consistent($urandom_range(3) == 0 ? 4000000 : 3000));
            else
                send_fix(make_noise());
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= quiet_receiver || ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fixes.size() == 0)
            begin
                $error("unexpected result beat %p", out_data);
                failures++;
            end
            else
            begin
                want = expected_fixes.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    failures++;
                end
                if (out_data.pos_x !== want.pos_x)
                begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, out_data.pos_x);
                    failures++;
                end
                if (out_data.pos_y !== want.pos_y)
                begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, out_data.pos_y);
                    failures++;
                end
            end
        end
    end

    // Counts cycles without any accepted beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        failures = 0;
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        tolerance = TOL_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_tolerance_settings();
        test_random(1400);
        drain_then_idle();
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/tri3a_pkg.sv
src/tri3a_div.sv
src/trilateration_three_anchors_top.sv
src/tri3a_chk.sv
tb/sv/testbench.sv
